[design/mts_pkg.sv]
`default_nettype none

package mts_pkg;

  // Fixed field widths of the transfer payloads.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OCC_W   = 11;

  // Action codes carried by a request.
  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  // Status codes returned with every response.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_FILL
  } state_e;

  // Request payload. The action field can carry the unused code 3.
  typedef struct packed {
    logic [1:0]                action;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  // Response payload.
  typedef struct packed {
    logic signed [VALUE_W-1:0] top_value;
    logic signed [VALUE_W-1:0] min_value;
    logic [OCC_W-1:0]          occupancy;
    logic                      is_empty;
    logic [1:0]                status;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    push;
    logic    pop;
    logic    fill;
    logic    out_load;
    status_e status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
  } stat_t;

endpackage

`default_nettype wire

[design/mts_req_if.sv]
`default_nettype none

interface mts_req_if;
  logic          valid;
  logic          ready;
  mts_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/mts_rsp_if.sv]
`default_nettype none

interface mts_rsp_if;
  logic          valid;
  logic          ready;
  mts_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/mts_datapath.sv]
`default_nettype none

module mts_datapath #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mts_pkg::cmd_t cmd_i,
  input  wire logic signed [mts_pkg::VALUE_W-1:0] value_i,
  output mts_pkg::stat_t     stat_o,
  output mts_pkg::rsp_t      rsp_o
);
  import mts_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  // Both stacks live in single-port style arrays with a registered read.
  logic signed [VALUE_W-1:0] main_mem [STACK_DEPTH];
  logic signed [VALUE_W-1:0] min_mem  [STACK_DEPTH];

  logic [CW-1:0]             main_cnt_q, main_cnt_d;
  logic [CW-1:0]             min_cnt_q, min_cnt_d;
  logic signed [VALUE_W-1:0] main_top_q, main_top_d;
  logic signed [VALUE_W-1:0] min_top_q, min_top_d;
  logic signed [VALUE_W-1:0] rd_main_q, rd_min_q;
  rsp_t                      rsp_q, rsp_d;

  logic          min_push;
  logic          min_pop;
  logic [CW-1:0] main_rd_cnt;
  logic [CW-1:0] min_rd_cnt;

  assign stat_o.full  = (main_cnt_q == CW'(STACK_DEPTH));
  assign stat_o.empty = (main_cnt_q == '0);

  // A pushed value joins the minimum stack when it is a new minimum or a tie.
  assign min_push = (min_cnt_q != CW'(STACK_DEPTH)) &&
                    ((min_cnt_q == '0) || (value_i <= min_top_q));

  // A pop leaves the minimum stack when its top is the element popped.
  assign min_pop = (min_cnt_q != '0) && (min_top_q == main_top_q);

  // Read addresses point at the entries that become the new tops after a pop.
  assign main_rd_cnt = main_cnt_q - CW'(2);
  assign min_rd_cnt  = min_pop ? (min_cnt_q - CW'(2)) : (min_cnt_q - CW'(1));

  // Next values of the counts and the cached tops.
  always_comb begin
    main_cnt_d = main_cnt_q;
    min_cnt_d  = min_cnt_q;
    main_top_d = main_top_q;
    min_top_d  = min_top_q;
    if (cmd_i.push) begin
      main_cnt_d = main_cnt_q + CW'(1);
      main_top_d = value_i;
      if (min_push) begin
        min_cnt_d = min_cnt_q + CW'(1);
        min_top_d = value_i;
      end
    end
    if (cmd_i.pop) begin
      main_cnt_d = main_cnt_q - CW'(1);
      if (min_pop) begin
        min_cnt_d = min_cnt_q - CW'(1);
      end
    end
    if (cmd_i.fill) begin
      main_top_d = rd_main_q;
      min_top_d  = rd_min_q;
    end
  end

  // Response built from the state as it stands after the item.
  always_comb begin
    rsp_d.top_value = (main_cnt_d != '0) ? main_top_d : '0;
    rsp_d.min_value = ((main_cnt_d != '0) && (min_cnt_d != '0)) ? min_top_d : '0;
    rsp_d.occupancy = OCC_W'(main_cnt_d);
    rsp_d.is_empty  = (main_cnt_d == '0);
    rsp_d.status    = cmd_i.status;
  end

  // Control state: the counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_cnt_q <= '0;
      min_cnt_q  <= '0;
    end else begin
      main_cnt_q <= main_cnt_d;
      min_cnt_q  <= min_cnt_d;
    end
  end

  // Payload registers: cached tops and the response.
  always_ff @(posedge clk_i) begin
    main_top_q <= main_top_d;
    min_top_q  <= min_top_d;
    if (cmd_i.out_load) begin
      rsp_q <= rsp_d;
    end
  end

  // Memory writes on a push and registered reads on a pop.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      main_mem[main_cnt_q[AW-1:0]] <= value_i;
      if (min_push) begin
        min_mem[min_cnt_q[AW-1:0]] <= value_i;
      end
    end
    if (cmd_i.pop) begin
      rd_main_q <= main_mem[main_rd_cnt[AW-1:0]];
      rd_min_q  <= min_mem[min_rd_cnt[AW-1:0]];
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

[design/mts_ctrl.sv]
`default_nettype none

module mts_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic [1:0]     in_action_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire mts_pkg::stat_t stat_i,
  output mts_pkg::cmd_t       cmd_o
);
  import mts_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_xfer;
  logic   out_xfer;

  // A new request is taken in the idle state once the response slot is free or freeing.
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_valid_q && out_ready_i;

  // Next state and datapath commands.
  always_comb begin
    state_d        = state_q;
    cmd_o.push     = 1'b0;
    cmd_o.pop      = 1'b0;
    cmd_o.fill     = 1'b0;
    cmd_o.out_load = 1'b0;
    cmd_o.status   = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_action_i)
            ACT_PUSH: begin
              cmd_o.out_load = 1'b1;
              if (stat_i.full) begin
                cmd_o.status = ST_OVERFLOW;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            ACT_POP: begin
              if (stat_i.empty) begin
                cmd_o.status   = ST_UNDERFLOW;
                cmd_o.out_load = 1'b1;
              end else begin
                cmd_o.pop = 1'b1;
                state_d   = S_FILL;
              end
            end
            default: begin
              cmd_o.out_load = 1'b1;
            end
          endcase
        end
      end
      S_FILL: begin
        cmd_o.fill     = 1'b1;
        cmd_o.out_load = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Response valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_xfer) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A pop on a non-empty stack always goes through the fill state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (in_action_i == ACT_POP) && !stat_i.empty) |=> (state_q == S_FILL))
    else $error("pop did not enter the fill state");

  // The fill state never finds a response still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> !out_valid_q)
    else $error("response slot busy during fill");

  // The fill state produces a response in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |=> (out_valid_q && (state_q == S_IDLE)))
    else $error("fill did not produce a response");

  // Every request that needs no fill answers in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !cmd_o.pop) |=> out_valid_q)
    else $error("request produced no response");

endmodule

`default_nettype wire

[design/min_tracking_stack.sv]
`default_nettype none

// Signed 32-bit stack that reports its running minimum with every response.
// Requests arrive on req_i (action: push, pop or query, plus a value for push);
// each accepted request returns exactly one response on rsp_o with the top,
// the minimum, the occupancy, an empty flag and a status code.
// A push on a full stack reports overflow and a pop on an empty stack reports
// underflow; neither changes the stack. Action code 3 behaves as a query.
// Push, query and error cases answer in the cycle after the transfer; a pop
// that removes an element answers after its fill state, because the new
// tops of both stacks come from a registered read of the stack memories.
// Throughput: one request per cycle for push and query while responses are
// taken; a pop that removes an element holds off the next through that read.
// The response sits in an output register; the next request is taken while
// it waits as long as the receiver takes it in the same cycle. While the
// receiver stalls, req_i.ready stays low once a response is pending.
// Reset clears both counts, so the stack is empty right after reset; the
// memories need no clearing.
module min_tracking_stack #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mts_req_if.sink    req_i,
  mts_rsp_if.source  rsp_o
);
  import mts_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_action_i (req_i.data.action),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .value_i (req_i.data.value),
    .stat_o  (stat),
    .rsp_o   (rsp_o.data)
  );

endmodule

`default_nettype wire

[dv/mts_tb_pkg.sv]
`default_nettype none

package mts_tb_pkg;

  import mts_pkg::*;

  // Tracks the stack contents for every accepted request and compares each
  // response against the view of the stack that the request should leave.
  class stack_scoreboard;

    int unsigned depth;
    logic [VALUE_W-1:0] main_mem[];
    logic [VALUE_W-1:0] min_mem[];
    int unsigned main_cnt;
    int unsigned min_cnt;

    // One entry per accepted request that still waits for its response.
    rsp_t stack_view_q[$];

    int unsigned errors;
    int unsigned compared;
    int unsigned n_push;
    int unsigned n_pop;
    int unsigned n_query;
    int unsigned n_overflow;
    int unsigned n_underflow;
    int unsigned peak_occ;

    function new(int unsigned stack_depth);
      depth    = stack_depth;
      main_mem = new[stack_depth];
      min_mem  = new[stack_depth];
    endfunction

    function int unsigned occupancy();
      return main_cnt;
    endfunction

    function int unsigned outstanding();
      return stack_view_q.size();
    endfunction

    // Applies one action to the stack copy and returns the resulting view.
    function rsp_t apply_action(req_t r);
      rsp_t               view;
      status_e            st;
      logic [VALUE_W-1:0] val;
      st  = ST_OK;
      val = r.value;
      case (r.action)
        ACT_PUSH: begin
          n_push++;
          if (main_cnt >= depth) begin
            st = ST_OVERFLOW;
            n_overflow++;
          end else begin
            main_mem[main_cnt] = val;
            main_cnt++;
            // Equal values go onto the minimum stack too, so duplicates pop cleanly.
            if (min_cnt < depth) begin
              if (min_cnt == 0 || $signed(val) <= $signed(min_mem[min_cnt-1])) begin
                min_mem[min_cnt] = val;
                min_cnt++;
              end
            end
          end
        end
        ACT_POP: begin
          n_pop++;
          if (main_cnt == 0) begin
            st = ST_UNDERFLOW;
            n_underflow++;
          end else begin
            if (min_cnt > 0 && min_mem[min_cnt-1] == main_mem[main_cnt-1]) min_cnt--;
            main_cnt--;
          end
        end
        default: begin
          // Query and the unused action code leave the stack alone.
          n_query++;
        end
      endcase
      if (main_cnt > peak_occ) peak_occ = main_cnt;
      view.top_value = (main_cnt > 0) ? main_mem[main_cnt-1] : '0;
      view.min_value = (main_cnt > 0 && min_cnt > 0) ? min_mem[min_cnt-1] : '0;
      view.occupancy = OCC_W'(main_cnt);
      view.is_empty  = (main_cnt == 0);
      view.status    = st;
      return view;
    endfunction

    // Called for every request transfer.
    function void take_request(req_t r);
      stack_view_q.push_back(apply_action(r));
    endfunction

    // Called for every response transfer.
    function void check_response(rsp_t got);
      rsp_t want;
      if (stack_view_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected response: top %0d min %0d occ %0d empty %0b status %0d",
                   got.top_value, got.min_value, got.occupancy, got.is_empty, got.status);
        return;
      end
      want = stack_view_q.pop_front();
      compared++;
      if (got.top_value !== want.top_value || got.min_value !== want.min_value ||
          got.occupancy !== want.occupancy || got.is_empty !== want.is_empty ||
          got.status !== want.status) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch on response %0d:", compared);
          $display("  expected top %0d min %0d occ %0d empty %0b status %0d",
                   want.top_value, want.min_value, want.occupancy, want.is_empty,
                   want.status);
          $display("  actual   top %0d min %0d occ %0d empty %0b status %0d",
                   got.top_value, got.min_value, got.occupancy, got.is_empty,
                   got.status);
        end
      end
    endfunction

  endclass

endpackage

`default_nettype wire

[dv/testbench.sv]
`default_nettype none

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import mts_pkg::*;
  import mts_tb_pkg::*;

  localparam int unsigned DEPTH        = 1024;
  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned UNWIND_ITEMS = 150;
  localparam int unsigned HANG_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned IDLE_PCT     = 37;

  localparam logic [1:0]         ACT_UNUSED = 2'd3;
  localparam logic [VALUE_W-1:0] VAL_MAX    = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VAL_MIN    = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VAL_NEG1   = 32'hFFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni;

  // Idle controls (no_idle shared by both sides, the receiver hold-off) and the watchdog count.
  logic no_idle;
  logic hold_req;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  stack_scoreboard sb;

  mts_req_if req_if ();
  mts_rsp_if rsp_if ();

  min_tracking_stack #(
    .STACK_DEPTH(DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  always #4 clk_i = ~clk_i;

  // Receiver: random stalls, stretches without stalls and one long hold-off.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req <= 1'b0;
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (no_idle) begin
      rsp_if.ready <= 1'b1;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Every response transfer is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT) begin
          $display("no transfer for %0d cycles", HANG_LIMIT);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // Offers one request, with an optional gap before it, until it is taken.
  task automatic send_request(input logic [1:0] act, input logic [VALUE_W-1:0] val);
    req_t r;
    int unsigned gap;
    r.action = act;
    r.value  = val;
    gap = 0;
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    sb.take_request(r);
  endtask

  // Stops offering and waits until every response has come back.
  task automatic wait_for_responses();
    req_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // Values lean toward small numbers and extremes so that duplicates and
  // equal minimums show up often.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return VALUE_W'($signed($urandom_range(0, 8)) - 4);
      3: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MAX;
          1:       return VAL_MIN;
          2:       return VAL_NEG1;
          default: return '0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_action(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return ACT_PUSH;
    if (r < 90) return ACT_POP;
    if (r < 96) return ACT_QUERY;
    return ACT_UNUSED;
  endfunction

  initial begin
    int unsigned random_items;
    int unsigned seg;
    int unsigned push_pct;
    int unsigned seg_len;

    rst_ni        = 1'b0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    quiet_cycles  = 0;
    req_if.valid  = 1'b0;
    req_if.data   = '0;
    rsp_if.ready  = 1'b0;
    sb = new(DEPTH);
    random_items = 0;
    seg = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-stack cases, extremes, equal minimums and underflow.
    send_request(ACT_QUERY, '0);
    send_request(ACT_POP, VAL_NEG1);
    send_request(ACT_UNUSED, VAL_NEG1);
    send_request(ACT_PUSH, '0);
    send_request(ACT_PUSH, VAL_MAX);
    send_request(ACT_PUSH, VAL_MIN);
    send_request(ACT_PUSH, VAL_MIN);
    send_request(ACT_PUSH, VAL_NEG1);
    send_request(ACT_QUERY, VAL_MAX);
    send_request(ACT_UNUSED, 32'h1234_5678);
    repeat (5) send_request(ACT_POP, '0);
    send_request(ACT_POP, '0);
    send_request(ACT_PUSH, VAL_MAX);
    send_request(ACT_PUSH, VAL_MAX);
    send_request(ACT_POP, '0);
    send_request(ACT_POP, '0);

    // Random segments with varying push bias; two run without idling, one
    // starts a long receiver hold-off, one ends with a full drain.
    while (random_items < RANDOM_ITEMS) begin
      push_pct = $urandom_range(15, 85);
      seg_len  = $urandom_range(25, 45);
      if (seg == 2) no_idle <= 1'b1;
      if (seg == 4) no_idle <= 1'b0;
      if (seg == 4) hold_req <= 1'b1;
      if (seg == 6) wait_for_responses();
      repeat (seg_len) begin
        send_request(pick_action(push_pct), pick_value());
        random_items++;
      end
      seg++;
    end

    // Climb to a full stack, push into it, then unwind part of the way.
    while (sb.occupancy() < DEPTH) send_request(pick_action(96), pick_value());
    repeat (4) send_request(ACT_PUSH, pick_value());
    send_request(ACT_QUERY, pick_value());
    repeat (UNWIND_ITEMS) send_request(pick_action(5), pick_value());

    wait_for_responses();
    repeat (8) @(posedge clk_i);

    $display("Ran %0d pushes, %0d pops and %0d queries; the stack peaked at %0d of %0d.",
             sb.n_push, sb.n_pop, sb.n_query, sb.peak_occ, DEPTH);
    $display("Saw %0d overflows and %0d underflows; %0d responses compared, %0d errors.",
             sb.n_overflow, sb.n_underflow, sb.compared, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
